>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on clk, disabled while rst_n is low
`define PDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk, also during reset
`define PDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDS_ASSERT(lbl, prop, msg)
`define PDS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> sv/pds_pkg.sv
// ----------------------------------------------------------------------------
// Pedestal subtractor package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 11;
  localparam int LIMIT_W    = 10;
  localparam int DELAY_W    = 7;
  localparam int CHANNELS   = 64;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STORE_W    = SAMPLE_W + ACC_W;

  localparam logic [SAMPLE_W-1:0] INIT_PED_RST = '0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST    = LIMIT_W'(10);
  localparam logic [DELAY_W-1:0]  DELAY_RST    = DELAY_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_PED      = 2'd0,
    REG_ACCUM_LIMIT   = 2'd1,
    REG_RESTORE_DELAY = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] init_ped;
    logic [LIMIT_W-1:0]         accum_limit;
    logic [DELAY_W-1:0]         restore_delay;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       valid_req;
    logic                       user_mark;
    logic                       last;
    logic                       keep;
    logic                       ready_req;
    logic                       clear;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] adjusted_sample;
    logic                       valid_out;
    logic                       user_out;
    logic                       keep_out;
    logic                       last_out;
  } result_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ped;
    logic [ACC_W-1:0]           acc;
  } store_word_t;

endpackage

>>> sv/pds_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pds_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds initial pedestal, accumulator limit and restore delay.
// ----------------------------------------------------------------------------
module pds_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pds_pkg::CFG_DATA_W-1:0] wr_data,
  output pds_pkg::cfg_t                  cfg
);

  pds_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode the register index of a transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (pds_pkg::cfg_reg_e'(wr_index))
        pds_pkg::REG_INIT_PED: begin
          cfg_nxt.init_ped = wr_data[pds_pkg::SAMPLE_W-1:0];
        end
        pds_pkg::REG_ACCUM_LIMIT: begin
          cfg_nxt.accum_limit = wr_data[pds_pkg::LIMIT_W-1:0];
        end
        pds_pkg::REG_RESTORE_DELAY: begin
          cfg_nxt.restore_delay = wr_data[pds_pkg::DELAY_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_ped      <= pds_pkg::INIT_PED_RST;
      cfg_r.accum_limit   <= pds_pkg::LIMIT_RST;
      cfg_r.restore_delay <= pds_pkg::DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/pds_tracker.sv
// ----------------------------------------------------------------------------
// Pedestal tracker
// Per-channel frugal median tracking, channel store and subtraction.
// ----------------------------------------------------------------------------
module pds_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  pds_pkg::item_t   item,
  input  pds_pkg::cfg_t    cfg,
  output pds_pkg::result_t result
);

  logic signed [pds_pkg::SAMPLE_W-1:0] wped_r, wped_nxt;
  logic signed [pds_pkg::SAMPLE_W-1:0] fill_ped_r, fill_ped_nxt;
  logic signed [pds_pkg::SAMPLE_W-1:0] held_r, held_nxt;
  logic [pds_pkg::ACC_W-1:0]           wacc_r, wacc_nxt;
  logic                                pend_r, pend_nxt;
  logic [pds_pkg::DELAY_W-1:0]         cnt_r, cnt_nxt;
  logic [pds_pkg::CH_W-1:0]            chan_r, chan_nxt;
  logic [pds_pkg::CHANNELS-1:0]        vld_r, vld_nxt;

  logic signed [pds_pkg::SAMPLE_W-1:0] ped_upd, adj;
  logic [pds_pkg::ACC_W-1:0]           acc_upd, acc_inc, acc_dec, neg_limit, pos_limit;
  logic [pds_pkg::DELAY_W-1:0]         cnt_inc;
  logic [pds_pkg::CH_W-1:0]            ch, ram_raddr;
  logic                                pkt_end, ram_we;
  logic [pds_pkg::STORE_W-1:0]         ram_rdata;
  pds_pkg::store_word_t                rd_word, stored, wr_word;

  // Channel store: pedestal and accumulator per channel
  pds_ram #(
    .WIDTH (pds_pkg::STORE_W),
    .DEPTH (pds_pkg::CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch),
    .wdata (wr_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word = pds_pkg::store_word_t'(ram_rdata);

  // Entries not written since clear read as the fill pedestal
  always_comb begin
    if (vld_r[chan_r]) begin
      stored = rd_word;
    end else begin
      stored.ped = fill_ped_r;
      stored.acc = '0;
    end
  end

  // Median step on the working values
  always_comb begin
    acc_inc   = wacc_r + pds_pkg::ACC_W'(1);
    acc_dec   = wacc_r - pds_pkg::ACC_W'(1);
    pos_limit = pds_pkg::ACC_W'(cfg.accum_limit);
    neg_limit = pds_pkg::ACC_W'(0) - pos_limit;
    ped_upd   = wped_r;
    acc_upd   = wacc_r;
    if (item.valid_req && item.keep) begin
      if (item.sample > wped_r) begin
        if (acc_inc == pos_limit) begin
          ped_upd = wped_r + pds_pkg::SAMPLE_W'(1);
          acc_upd = '0;
        end else begin
          acc_upd = acc_inc;
        end
      end else if (item.sample < wped_r) begin
        if (acc_dec == neg_limit) begin
          ped_upd = wped_r - pds_pkg::SAMPLE_W'(1);
          acc_upd = '0;
        end else begin
          acc_upd = acc_dec;
        end
      end
    end
  end

  // Next state for one item
  always_comb begin
    wped_nxt     = wped_r;
    wacc_nxt     = wacc_r;
    fill_ped_nxt = fill_ped_r;
    held_nxt     = held_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    vld_nxt      = vld_r;
    ch           = chan_r;
    cnt_inc      = cnt_r + pds_pkg::DELAY_W'(1);
    pkt_end      = item.last && item.user_mark && item.valid_req;
    wr_word.ped  = wped_r;
    wr_word.acc  = wacc_r;
    if (item.clear) begin
      fill_ped_nxt = cfg.init_ped;
      wped_nxt     = cfg.init_ped;
      wacc_nxt     = '0;
      pend_nxt     = 1'b0;
      cnt_nxt      = '0;
      vld_nxt      = '0;
      ch           = '0;
      held_nxt     = item.sample;
      adj          = item.sample - cfg.init_ped;
      wr_word.ped  = cfg.init_ped;
      wr_word.acc  = '0;
    end else if (item.ready_req) begin
      wped_nxt    = ped_upd;
      wacc_nxt    = acc_upd;
      held_nxt    = item.sample;
      adj         = item.sample - ped_upd;
      wr_word.ped = ped_upd;
      wr_word.acc = acc_upd;
      // Count a pending reload up to the restore delay, then take the store entry
      if (pend_r) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == cfg.restore_delay) begin
          wped_nxt = stored.ped;
          wacc_nxt = stored.acc;
          pend_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end
      if (item.last && item.user_mark) begin
        pend_nxt = 1'b1;
      end
    end else begin
      adj = held_r - wped_r;
    end
    // Save working values and advance the channel at a packet end
    chan_nxt = ch;
    ram_we   = 1'b0;
    if (pkt_end) begin
      ram_we      = step_en;
      vld_nxt[ch] = 1'b1;
      chan_nxt    = (ch == pds_pkg::CH_W'(pds_pkg::CHANNELS - 1)) ? '0 :
                    ch + pds_pkg::CH_W'(1);
    end
  end

  // Prefetch the entry of the channel that is current after this edge
  assign ram_raddr = step_en ? chan_nxt : chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wped_r     <= pds_pkg::INIT_PED_RST;
      fill_ped_r <= pds_pkg::INIT_PED_RST;
      held_r     <= '0;
      wacc_r     <= '0;
      pend_r     <= 1'b0;
      cnt_r      <= '0;
      chan_r     <= '0;
      vld_r      <= '0;
    end else if (step_en) begin
      wped_r     <= wped_nxt;
      fill_ped_r <= fill_ped_nxt;
      held_r     <= held_nxt;
      wacc_r     <= wacc_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
      chan_r     <= chan_nxt;
      vld_r      <= vld_nxt;
    end
  end

  // Flags pass straight through
  always_comb begin
    result.adjusted_sample = adj;
    result.valid_out       = item.valid_req;
    result.user_out        = item.user_mark;
    result.keep_out        = item.keep;
    result.last_out        = item.last;
  end

endmodule

>>> sv/multichannel_pedestal_subtractor_unit.sv
// ----------------------------------------------------------------------------
// Multichannel pedestal subtractor
// Subtracts a tracked per-channel pedestal from a stream of ADC samples.
// ----------------------------------------------------------------------------
// An item passes the input register, then the result register, on its way from
//   input transfer to result transfer; result valid rises as the input register
//   hands the item on. The tracker state updates as an item leaves
//   the input register.
// Throughput: one item per cycle while the result channel does not stall.
// Reset: synchronous, active low; clears both stages, the channel state and
//   the store valid bits and loads register defaults.
`include "assert_macros.svh"

module multichannel_pedestal_subtractor_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pds_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                  in_valid_req,
  input  logic                                  in_user_mark,
  input  logic                                  in_last,
  input  logic                                  in_keep,
  input  logic                                  in_ready_req,
  input  logic                                  in_clear,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pds_pkg::SAMPLE_W-1:0]   out_adjusted_sample,
  output logic                                  out_valid_out,
  output logic                                  out_user_out,
  output logic                                  out_keep_out,
  output logic                                  out_last_out,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pds_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pds_pkg::CFG_DATA_W-1:0]        cfg_data
);

  pds_pkg::cfg_t    cfg;
  pds_pkg::item_t   in_item, s1_item_r;
  pds_pkg::result_t res, out_res_r;
  logic             s1_valid_r, out_valid_r, s1_adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  pds_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pack the input fields
  always_comb begin
    in_item.sample    = in_sample;
    in_item.valid_req = in_valid_req;
    in_item.user_mark = in_user_mark;
    in_item.last      = in_last;
    in_item.keep      = in_keep;
    in_item.ready_req = in_ready_req;
    in_item.clear     = in_clear;
  end

  // Advance the input stage when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  pds_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (res)
  );

  // Drive the result channel
  assign out_valid           = out_valid_r;
  assign out_adjusted_sample = out_res_r.adjusted_sample;
  assign out_valid_out       = out_res_r.valid_out;
  assign out_user_out        = out_res_r.user_out;
  assign out_keep_out        = out_res_r.keep_out;
  assign out_last_out        = out_res_r.last_out;

  // Checks on the two-stage control
  `PDS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")
  `PDS_ASSERT(a_s1_moves, (s1_valid_r && !out_valid_r) |=> out_valid,
              "input stage item did not reach result register")
  `PDS_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty result")
  `PDS_ASSERT(a_full_stall, (out_valid && !out_ready && s1_valid_r) |-> !in_ready,
              "transfer accepted while both stages full")

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Pedestal subtractor testbench
// Drives directed and random sample packets with random idle cycles on both
// channels, runs several register settings, and checks each result against
// an in-bench model of the per-channel median pedestal tracker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pds_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int IDLE_MAX     = 5;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 260;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample    = '0;
  logic                       in_valid_req = 1'b0;
  logic                       in_user_mark = 1'b0;
  logic                       in_last      = 1'b0;
  logic                       in_keep      = 1'b0;
  logic                       in_ready_req = 1'b0;
  logic                       in_clear     = 1'b0;

  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_adjusted_sample;
  logic                       out_valid_out;
  logic                       out_user_out;
  logic                       out_keep_out;
  logic                       out_last_out;

  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;

  multichannel_pedestal_subtractor_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_valid_req        (in_valid_req),
    .in_user_mark        (in_user_mark),
    .in_last             (in_last),
    .in_keep             (in_keep),
    .in_ready_req        (in_ready_req),
    .in_clear            (in_clear),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_adjusted_sample (out_adjusted_sample),
    .out_valid_out       (out_valid_out),
    .out_user_out        (out_user_out),
    .out_keep_out        (out_keep_out),
    .out_last_out        (out_last_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Stimulus and prediction queues
  item_t   sample_q[$];
  result_t predicted_results[$];
  item_t   cur_item;
  int      queued_count = 0;
  int      sent_count   = 0;
  int      recv_count   = 0;
  int      error_count  = 0;
  int      cycle_count  = 0;
  int      send_gap     = 0;
  int      recv_wait    = 0;

  // Register copies held by the model
  logic signed [SAMPLE_W-1:0] reg_init_ped;
  logic [LIMIT_W-1:0]         reg_limit;
  logic [DELAY_W-1:0]         reg_delay;

  // Tracker state held by the model
  logic signed [SAMPLE_W-1:0] ped_mem[CHANNELS];
  logic [ACC_W-1:0]           acc_mem[CHANNELS];
  logic [CH_W-1:0]            cur_chan;
  logic signed [SAMPLE_W-1:0] run_ped;
  logic [ACC_W-1:0]           run_acc;
  logic                       reload_armed;
  logic [DELAY_W-1:0]         reload_count;
  logic signed [SAMPLE_W-1:0] last_sample;

  // Per-packet baseline around which random samples scatter
  logic signed [SAMPLE_W-1:0] chan_base[CHANNELS];

  // Advance the tracker by one item and return the adjusted sample with flags
  function automatic result_t subtract_pedestal(item_t it);
    result_t                    res;
    logic signed [SAMPLE_W-1:0] save_ped;
    logic [ACC_W-1:0]           save_acc;
    logic [ACC_W-1:0]           neg_lim;
    logic [CH_W-1:0]            ch;
    ch      = cur_chan;
    neg_lim = '0 - ACC_W'(reg_limit);
    if (it.clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ped_mem[i] = reg_init_ped;
        acc_mem[i] = '0;
      end
      cur_chan     = '0;
      ch           = '0;
      run_acc      = '0;
      run_ped      = reg_init_ped;
      reload_armed = 1'b0;
      reload_count = '0;
      res.adjusted_sample = it.sample - run_ped;
      save_ped    = run_ped;
      save_acc    = run_acc;
      last_sample = it.sample;
    end else if (it.ready_req) begin
      // step the frugal median on kept, valid samples
      if (it.valid_req && it.keep) begin
        if ($signed(it.sample) > $signed(run_ped)) begin
          run_acc = run_acc + 1'b1;
          if (run_acc == ACC_W'(reg_limit)) begin
            run_ped = run_ped + SAMPLE_W'(1);
            run_acc = '0;
          end
        end else if ($signed(it.sample) < $signed(run_ped)) begin
          run_acc = run_acc - 1'b1;
          if (run_acc == neg_lim) begin
            run_ped = run_ped - SAMPLE_W'(1);
            run_acc = '0;
          end
        end
      end
      res.adjusted_sample = it.sample - run_ped;
      save_ped    = run_ped;
      save_acc    = run_acc;
      last_sample = it.sample;
      // count a pending reload up to the delay, then load the current channel entry
      if (reload_armed) begin
        reload_count = reload_count + 1'b1;
        if (reload_count == reg_delay) begin
          run_acc      = acc_mem[ch];
          run_ped      = ped_mem[ch];
          reload_armed = 1'b0;
          reload_count = '0;
        end
      end
      if (it.last && it.user_mark) reload_armed = 1'b1;
    end else begin
      // downstream not ready: repeat the held sample
      res.adjusted_sample = last_sample - run_ped;
      save_ped = run_ped;
      save_acc = run_acc;
    end
    // packet end: store working values and move to the next channel
    if (it.last && it.user_mark && it.valid_req) begin
      ped_mem[ch] = save_ped;
      acc_mem[ch] = save_acc;
      cur_chan    = (ch == CH_W'(CHANNELS - 1)) ? '0 : ch + 1'b1;
    end
    res.valid_out = it.valid_req;
    res.user_out  = it.user_mark;
    res.keep_out  = it.keep;
    res.last_out  = it.last;
    return res;
  endfunction

  // Idle cycles before the next transfer, with stretches of none
  function automatic int draw_idle(int count, int period, int phases);
    if ((count / period) % phases == 1) return 0;
    return $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic item_t make_item(logic [SAMPLE_W-1:0] s, bit v, bit u, bit l,
                                      bit k, bit r, bit c);
    item_t it;
    it.sample    = s;
    it.valid_req = v;
    it.user_mark = u;
    it.last      = l;
    it.keep      = k;
    it.ready_req = r;
    it.clear     = c;
    return it;
  endfunction

  function void check_field(string name, logic [SAMPLE_W-1:0] want,
                            logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Random sample: mostly near the packet baseline, some anywhere, some at the rails
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] base);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return base + SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
    if (roll < 90) return SAMPLE_W'($urandom);
    if (roll < 95) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return base;
  endfunction

  task automatic queue_item(item_t it);
    sample_q.push_back(it);
    queued_count++;
  endtask

  // Mostly well-formed packets with random content, plus loose noise items
  task automatic gen_traffic(int n_items);
    int                  made;
    int                  len;
    int                  pkt;
    logic [SAMPLE_W-1:0] base;
    item_t               it;
    made = 0;
    pkt  = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        it = make_item(SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 49) == 0);
        queue_item(it);
        made++;
      end else begin
        len  = $urandom_range(1, 12);
        base = chan_base[pkt % CHANNELS];
        for (int j = 0; j < len; j++) begin
          it = make_item(pick_sample(base), $urandom_range(0, 99) < 95,
                         1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 99) < 90,
                         $urandom_range(0, 99) < 85, $urandom_range(0, 399) == 0);
          if (j == len - 1) begin
            it.last      = 1'b1;
            it.user_mark = 1'b1;
            it.valid_req = $urandom_range(0, 99) < 92;
          end
          queue_item(it);
          made++;
        end
        pkt++;
      end
    end
  endtask

  // Wait until every queued item is sent and every result has come back
  task automatic wait_idle();
    while (sent_count != queued_count || predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; upper bits beyond the field width are don't-care
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = value;
    case (idx)
      REG_ACCUM_LIMIT:   word[CFG_DATA_W-1:LIMIT_W] = (CFG_DATA_W-LIMIT_W)'($urandom);
      REG_RESTORE_DELAY: word[CFG_DATA_W-1:DELAY_W] = (CFG_DATA_W-DELAY_W)'($urandom);
      default: ;
    endcase
    cfg_index <= idx;
    cfg_data  <= word;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_INIT_PED:      reg_init_ped = word;
      REG_ACCUM_LIMIT:   reg_limit    = word[LIMIT_W-1:0];
      REG_RESTORE_DELAY: reg_delay    = word[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  // New register setting, then a block of random traffic
  task automatic run_phase(bit set_init, logic [SAMPLE_W-1:0] init_ped,
                           logic [LIMIT_W-1:0] limit, logic [DELAY_W-1:0] delay);
    if (set_init) write_reg(REG_INIT_PED, init_ped);
    write_reg(REG_ACCUM_LIMIT, CFG_DATA_W'(limit));
    write_reg(REG_RESTORE_DELAY, CFG_DATA_W'(delay));
    for (int i = 0; i < CHANNELS; i++)
      chan_base[i] = reg_init_ped + SAMPLE_W'($urandom_range(0, 60)) - SAMPLE_W'(30);
    // clear so every store entry takes the new initial pedestal
    if (set_init) queue_item(make_item(SAMPLE_W'($urandom), 1, 0, 0, 1, 1, 1));
    gen_traffic(PHASE_ITEMS);
    wait_idle();
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive input transfers from the pending queue
  always @(posedge clk) begin : drive_inputs
    logic holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predicted_results.push_back(subtract_pedestal(cur_item));
        sent_count++;
        send_gap = draw_idle(sent_count, 150, 4);
      end
      if (!holding) begin
        if (send_gap == 0 && sample_q.size() != 0) begin
          cur_item = sample_q.pop_front();
          in_sample    <= cur_item.sample;
          in_valid_req <= cur_item.valid_req;
          in_user_mark <= cur_item.user_mark;
          in_last      <= cur_item.last;
          in_keep      <= cur_item.keep;
          in_ready_req <= cur_item.ready_req;
          in_clear     <= cur_item.clear;
          in_valid     <= 1'b1;
        end else begin
          if (send_gap != 0) send_gap--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept results, compare with the oldest prediction, pace out_ready
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no prediction pending");
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("adjusted_sample", want.adjusted_sample, out_adjusted_sample);
          check_field("valid_out", want.valid_out, out_valid_out);
          check_field("user_out", want.user_out, out_user_out);
          check_field("keep_out", want.keep_out, out_keep_out);
          check_field("last_out", want.last_out, out_last_out);
        end
        recv_count++;
        // hold off long enough twice to back the block up into its input
        if (recv_count == 300 || recv_count == 1100) recv_wait = LONG_HOLD;
        else recv_wait = draw_idle(recv_count, 170, 3);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_ready <= (recv_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_pedestal_subtractor_unit regression: fail");
      $finish;
    end
  end

  // Test sequence
  initial begin
    reg_init_ped = INIT_PED_RST;
    reg_limit    = LIMIT_RST;
    reg_delay    = DELAY_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      ped_mem[i] = INIT_PED_RST;
      acc_mem[i] = '0;
    end
    cur_chan     = '0;
    run_ped      = INIT_PED_RST;
    run_acc      = '0;
    reload_armed = 1'b0;
    reload_count = '0;
    last_sample  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items on reset register values: limit 10, delay 3
    queue_item(make_item(16'h7FFF, 1, 0, 0, 1, 1, 0)); // above: count up
    queue_item(make_item(16'h8000, 1, 0, 0, 1, 1, 0)); // below: count down
    queue_item(make_item(16'h0000, 1, 0, 0, 1, 1, 0)); // equal: hold count
    queue_item(make_item(16'd100,  1, 0, 0, 0, 1, 0)); // keep low: no update
    queue_item(make_item(16'd100,  0, 0, 0, 1, 1, 0)); // valid low: no update
    queue_item(make_item(16'd555,  1, 1, 0, 1, 0, 0)); // ready low: repeat held sample
    repeat (10) queue_item(make_item(16'd50, 1, 0, 0, 1, 1, 0)); // pedestal steps up
    queue_item(make_item(16'd7, 1, 1, 1, 1, 1, 0));    // packet end: save, advance, arm
    repeat (3) queue_item(make_item(16'hFFF0, 1, 0, 0, 1, 1, 0)); // reload on third
    queue_item(make_item(16'd9, 1, 1, 1, 1, 0, 0));    // packet end, ready low: save and advance, no arm
    queue_item(make_item(16'd9, 0, 1, 1, 1, 1, 0));    // end flags without valid: arm only
    queue_item(make_item(16'd9, 1, 0, 1, 1, 1, 0));    // last without user
    queue_item(make_item(16'hFFFF, 1, 1, 1, 1, 1, 1)); // clear with packet end flags
    wait_idle();

    // Register sweeps; phases without a new pedestal keep the accumulator,
    // so a smaller limit leaves it counting past the limit
    run_phase(1, 16'hFED4, 10'd1, 7'd1);
    run_phase(0, '0, 10'd1023, 7'd127);
    run_phase(0, '0, 10'd2, 7'd5);
    run_phase(1, 16'h7FFF, 10'd3, 7'd2);
    run_phase(1, 16'h8000, 10'd1, 7'd127);
    run_phase(1, SAMPLE_W'($urandom), LIMIT_W'($urandom_range(1, 16)),
              DELAY_W'($urandom_range(1, 8)));

    if (error_count == 0 && predicted_results.size() == 0)
      $display("multichannel_pedestal_subtractor_unit regression: pass");
    else
      $display("multichannel_pedestal_subtractor_unit regression: fail");
    $finish;
  end

endmodule
